[hw/rtl/cdq_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg: shared types and constants of the circular deque unit
// Operation codes, field widths and the per-cell control word.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int MODE_W  = 3;
	localparam int WORD_W  = 32;
	localparam int COUNT_W = 5;

	localparam logic [COUNT_W-1:0] CAP_RESET = 5'd16;

	typedef enum logic [MODE_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_REAR  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_REAR   = 3'd3,
		OP_PEEK       = 3'd4
	} op_t;

	typedef struct packed {
		logic push_front;
		logic push_rear;
		logic pop_front;
	} cell_ctl_t;

endpackage : cdq_pkg
`default_nettype wire

[hw/rtl/cdq_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_cell: one slot of the deque chain
// Holds one word; shifts toward the rear on a front push, toward the front
// on a front pop, and loads the pushed word on a rear push at its position.
// ----------------------------------------------------------------------------
module cdq_cell #(
	parameter int IDX = 0
) (
	input  wire logic                           clk,
	input  wire cdq_pkg::cell_ctl_t             ctl,
	input  wire logic [cdq_pkg::COUNT_W-1:0]    count,
	input  wire logic [cdq_pkg::WORD_W-1:0]     push_word,
	input  wire logic [cdq_pkg::WORD_W-1:0]     left_word,
	input  wire logic [cdq_pkg::WORD_W-1:0]     right_word,
	output logic      [cdq_pkg::WORD_W-1:0]     word,
	output logic      [cdq_pkg::WORD_W-1:0]     rear_word
);
	import cdq_pkg::*;

	logic [WORD_W-1:0] word_q;
	logic              at_tail;
	logic              is_last;

	assign at_tail = (int'(count) == IDX);
	assign is_last = (int'(count) == IDX + 1);

	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			word_q <= left_word;
		end else if (ctl.pop_front) begin
			word_q <= right_word;
		end else if (ctl.push_rear && at_tail) begin
			word_q <= push_word;
		end
	end

	assign word      = word_q;
	assign rear_word = is_last ? word_q : '0;

endmodule : cdq_cell
`default_nettype wire

[hw/rtl/circular_deque_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque_unit: double-ended queue of 32-bit words
// A row of word cells with the front in cell 0; a small controller keeps the
// entry count and the capacity register.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one operation per beat: s_tuser = mode, s_tdata = value.
//   m_* returns one result per operation: ok, empty/full flags in m_tuser,
//   entry count and front/rear words in m_tdata.
//   A beat accepted at one edge has its result valid from the next cycle.
//   One operation per cycle is sustained while m_tready stays high; the
//   single output slot is refilled in the cycle it is taken.
//   When the receiver stalls, the result is held and s_tready drops until
//   the slot is taken. Front and rear words come straight from the cells,
//   which do not change until the next operation is accepted.
//   cfg_we writes the capacity; it takes effect only while the queue is
//   empty. A value of 0 acts as 1, a value above DEPTH acts as DEPTH.
//   Reset empties the queue, sets capacity to 16 and clears the output slot.
//   Cell contents are not reset; they are never shown before being written.
// ----------------------------------------------------------------------------
module circular_deque_unit #(
	parameter int DEPTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] value
	input  wire logic [2:0]  s_tuser,   // [2:0] mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [71:0]      m_tdata,   // [4:0] entries, [36:5] front_value,
	                                    // [68:37] rear_value, [71:69] zero
	output logic [2:0]       m_tuser    // [0] ok, [1] is_empty, [2] is_full
);
	import cdq_pkg::*;

	localparam int CAP_MAX = (DEPTH < 31) ? DEPTH : 31;
	localparam logic [COUNT_W-1:0] CAP_MAX_W = COUNT_W'(CAP_MAX);

	logic [COUNT_W-1:0] cap_q;
	logic [COUNT_W-1:0] count_q;
	logic               valid_q;
	logic               ok_q;

	logic [COUNT_W-1:0] eff_cap;
	logic               full;
	logic               empty;
	logic               accept;
	op_t                op;
	logic               ok_d;
	logic [COUNT_W-1:0] count_d;
	cell_ctl_t          ctl;

	logic [WORD_W-1:0]  cell_word [DEPTH];
	logic [WORD_W-1:0]  cell_rear [DEPTH];
	logic [WORD_W-1:0]  rear_word;
	logic [WORD_W-1:0]  front_word;

	assign eff_cap = (cap_q == '0) ? COUNT_W'(1) :
	                 ((cap_q > CAP_MAX_W) ? CAP_MAX_W : cap_q);
	assign full    = (count_q >= eff_cap);
	assign empty   = (count_q == '0);

	assign s_tready = !valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign op       = op_t'(s_tuser);

	always_comb begin
		ctl     = '0;
		ok_d    = 1'b0;
		count_d = count_q;
		case (op)
			OP_PUSH_FRONT: begin
				if (!full) begin
					ctl.push_front = accept;
					ok_d           = 1'b1;
					count_d        = count_q + COUNT_W'(1);
				end
			end
			OP_PUSH_REAR: begin
				if (!full) begin
					ctl.push_rear = accept;
					ok_d          = 1'b1;
					count_d       = count_q + COUNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (!empty) begin
					ctl.pop_front = accept;
					ok_d          = 1'b1;
					count_d       = count_q - COUNT_W'(1);
				end
			end
			OP_POP_REAR: begin
				if (!empty) begin
					ok_d    = 1'b1;
					count_d = count_q - COUNT_W'(1);
				end
			end
			OP_PEEK: begin
				ok_d = 1'b1;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q   <= CAP_RESET;
			count_q <= '0;
			valid_q <= 1'b0;
			ok_q    <= 1'b0;
		end else begin
			if (cfg_we && empty) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				count_q <= count_d;
				ok_q    <= ok_d;
				valid_q <= 1'b1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_W-1:0] left_w;
		logic [WORD_W-1:0] right_w;
		if (i == 0) begin : g_first
			assign left_w = s_tdata;
		end else begin : g_mid
			assign left_w = cell_word[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = '0;
		end else begin : g_inner
			assign right_w = cell_word[i+1];
		end
		cdq_cell #(
			.IDX(i)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.count      (count_q),
			.push_word  (s_tdata),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (cell_word[i]),
			.rear_word  (cell_rear[i])
		);
	end

	always_comb begin
		rear_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rear_word = rear_word | cell_rear[i];
		end
	end

	assign front_word = empty ? '0 : cell_word[0];

	assign m_tvalid = valid_q;
	assign m_tuser  = {full, empty, ok_q};
	assign m_tdata  = {3'b000, rear_word, front_word, count_q};

endmodule : circular_deque_unit
`default_nettype wire

[tb/sv/circular_deque_unit_test.sv]
// ----------------------------------------------------------------------------
// circular_deque_unit_test: self-checking bench for the circular deque unit
// Streams push, pop, peek and undefined operations at several capacities. A
// shadow deque predicts every result beat, and each one is compared field by
// field. Sender bursts, receiver stalls, a long receiver hold-off and
// capacity writes, including writes ignored while entries are held.
// ----------------------------------------------------------------------------
module circular_deque_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import cdq_pkg::*;

	localparam int          RING_DEPTH  = 16;
	localparam int          CLK_PERIOD  = 12;
	localparam int          LONG_HOLD   = 80;
	localparam int          PHASES      = 8;
	localparam int          PHASE_ITEMS = 48;
	localparam int          SETTLE      = 3;
	localparam int unsigned CYCLE_LIMIT = 300000;

	typedef struct packed {
		logic [2:0]  pad;
		logic [31:0] rear_value;
		logic [31:0] front_value;
		logic [4:0]  entries;
		logic        is_full;
		logic        is_empty;
		logic        ok;
	} deque_result_t;

	typedef enum int {RX_OPEN, RX_SOME, RX_SPARSE} rx_mood_t;

	class deque_tracker;
		logic [31:0]   ring [RING_DEPTH];
		int            head;
		int            tail;
		int            held;
		logic [4:0]    cap_reg;
		deque_result_t due [$];
		int            mismatches;

		function new();
			head = 0;
			tail = 0;
			held = 0;
			cap_reg = CAP_RESET;
			mismatches = 0;
		endfunction

		function int cap_in_use();
			if (cap_reg == 0)
				return 1;
			if (cap_reg > RING_DEPTH)
				return RING_DEPTH;
			return int'(cap_reg);
		endfunction

		function void set_capacity(logic [4:0] v);
			if (held != 0)
				return;
			cap_reg = v;
			head = 0;
			tail = 0;
		endfunction

		function void apply_op(logic [2:0] mode, logic [31:0] word);
			int            cap;
			bit            was_full;
			bit            was_empty;
			deque_result_t r;
			cap = cap_in_use();
			was_full = held >= cap;
			was_empty = held == 0;
			head = head % cap;
			tail = tail % cap;
			r = '0;
			case (mode)
				OP_PUSH_FRONT: begin
					if (!was_full) begin
						head = (head == 0) ? cap - 1 : head - 1;
						ring[head] = word;
						held++;
						r.ok = 1'b1;
					end
				end
				OP_PUSH_REAR: begin
					if (!was_full) begin
						ring[tail] = word;
						tail = (tail + 1 >= cap) ? 0 : tail + 1;
						held++;
						r.ok = 1'b1;
					end
				end
				OP_POP_FRONT: begin
					if (!was_empty) begin
						head = (head + 1 >= cap) ? 0 : head + 1;
						held--;
						r.ok = 1'b1;
					end
				end
				OP_POP_REAR: begin
					if (!was_empty) begin
						tail = (tail == 0) ? cap - 1 : tail - 1;
						held--;
						r.ok = 1'b1;
					end
				end
				OP_PEEK: begin
					r.ok = 1'b1;
				end
				default: begin
					r.ok = 1'b0;
				end
			endcase
			r.is_empty = held == 0;
			r.is_full = held >= cap;
			r.entries = 5'(held);
			if (held != 0) begin
				r.front_value = ring[head];
				r.rear_value = ring[(tail == 0) ? cap - 1 : tail - 1];
			end
			due.push_back(r);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10)
				$display("%0t mismatch: %s", $realtime, what);
		endfunction

		function void field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want)
				flag($sformatf("%s expected %h got %h", name, want, got));
		endfunction

		function void compare_result(logic [2:0] flags, logic [71:0] word);
			deque_result_t want;
			deque_result_t got;
			got = {word, flags};
			if (due.size() == 0) begin
				flag($sformatf("unexpected beat tuser=%h tdata=%h", flags, word));
				return;
			end
			want = due.pop_front();
			field("ok", 32'(want.ok), 32'(got.ok));
			field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
			field("is_full", 32'(want.is_full), 32'(got.is_full));
			field("entries", 32'(want.entries), 32'(got.entries));
			field("front_value", want.front_value, got.front_value);
			field("rear_value", want.rear_value, got.rear_value);
			field("pad", 32'(want.pad), 32'(got.pad));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;
	logic [2:0]  m_tuser;

	deque_tracker book;
	int          burst_left = 0;
	int          holds_asked = 0;
	int unsigned cycles = 0;

	circular_deque_unit uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("circular_deque_unit_test: done, errors");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			book.compare_result(m_tuser, m_tdata);
	end

	// receiver: ready pattern by mood, long hold-off on request
	initial begin : rx
		int       served;
		int       hold_left;
		int       mood_left;
		rx_mood_t mood;
		served = 0;
		hold_left = 0;
		mood_left = 0;
		mood = RX_OPEN;
		forever begin
			@(posedge clk);
			if (served != holds_asked) begin
				served = holds_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (mood_left == 0) begin
					mood = rx_mood_t'($urandom_range(0, 2));
					mood_left = $urandom_range(16, 64);
				end
				mood_left--;
				case (mood)
					RX_OPEN:   m_tready <= 1'b1;
					RX_SOME:   m_tready <= ($urandom_range(0, 3) != 0);
					default:   m_tready <= ($urandom_range(0, 9) < 3);
				endcase
			end
		end
	end

	task automatic send_op(input logic [2:0] mode, input logic [31:0] word);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= word;
		do @(posedge clk); while (s_tready !== 1'b1);
		book.apply_op(mode, word);
		burst_left--;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (book.due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		book.set_capacity(v);
		cfg_we <= 1'b0;
	endtask

	task automatic drain();
		while (book.held != 0)
			send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR, $urandom);
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 11))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return 32'hffff_ffff;
			3:       return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	initial begin : stim
		logic [4:0]  cap_plan [PHASES];
		logic [2:0]  mode;
		bit          filling;
		int          roll;
		book = new();
		cap_plan = '{5'd31, 5'd17, 5'd16, 5'd2, 5'd3, 5'd8, 5'd0, 5'd16};
		cap_plan[5] = 5'($urandom_range(1, 31));
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, undefined modes, extremes at full depth
		send_op(OP_PEEK, 32'h1234_5678);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_REAR, '1);
		send_op(OP_PEEK + 3'd1, '0);
		send_op(OP_PEEK + 3'd2, '1);
		send_op(OP_PEEK + 3'd3, 32'h5a5a_a5a5);
		send_op(OP_PUSH_FRONT, 32'h8000_0000);
		send_op(OP_PUSH_REAR, 32'h7fff_ffff);
		send_op(OP_PUSH_FRONT, 32'hffff_ffff);
		send_op(OP_PUSH_REAR, 32'h0000_0000);
		send_op(OP_PEEK, '0);
		send_op(OP_PEEK + 3'd3, '1);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_REAR, '0);
		send_op(OP_POP_REAR, '0);
		send_op(OP_POP_FRONT, '0);
		send_op(OP_POP_FRONT, '0);

		// single entry: full refusals, write ignored while held, zero acts as one
		write_capacity(5'd1);
		send_op(OP_PUSH_REAR, 32'h5555_5555);
		send_op(OP_PUSH_FRONT, 32'h0f0f_0f0f);
		send_op(OP_PUSH_REAR, 32'hf0f0_f0f0);
		write_capacity(5'd31);
		send_op(OP_POP_REAR, '0);
		send_op(OP_POP_FRONT, '0);
		write_capacity(5'd0);
		send_op(OP_PUSH_FRONT, 32'haaaa_aaaa);
		send_op(OP_PUSH_REAR, 32'h3333_3333);
		send_op(OP_POP_FRONT, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			if (book.held != 0 && $urandom_range(0, 1))
				write_capacity(5'($urandom));
			drain();
			write_capacity(cap_plan[ph]);
			if (ph == 2 || ph == 5)
				holds_asked++;
			filling = 1'b1;
			repeat (PHASE_ITEMS) begin
				roll = $urandom_range(0, 99);
				if (roll < 4)
					mode = OP_PEEK + 3'($urandom_range(1, 3));
				else if (roll < 8)
					mode = OP_PEEK;
				else if ((roll < 80) == filling)
					mode = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
				else
					mode = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
				send_op(mode, pick_word());
				if (book.held >= book.cap_in_use())
					filling = 1'b0;
				else if (book.held == 0)
					filling = 1'b1;
				else if ($urandom_range(0, 29) == 0)
					filling = !filling;
			end
		end

		settle();
		if (book.due.size() != 0)
			book.flag($sformatf("%0d results never arrived", book.due.size()));
		if (book.mismatches == 0)
			$display("circular_deque_unit_test: done, clean");
		else
			$display("circular_deque_unit_test: done, errors");
		$finish;
	end

endmodule
